// ===== hdl/calendar_day_difference_unit_macros.svh =====
// Assertion shorthands for the calendar day difference unit.
`ifndef CALENDAR_DAY_DIFFERENCE_UNIT_MACROS_SVH
`define CALENDAR_DAY_DIFFERENCE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cdd_pkg.sv =====
package cdd_pkg;

    // Field widths.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int STATUS_W = 2;
    localparam int DIFF_W   = 22;

    // Internal widths.
    localparam int MAXY_W   = 16;            // holds any legal year bound
    localparam int DNUM_W   = 23;            // day number for any 14-bit year
    localparam int QUOT_W   = YEAR_W - 2;    // year divided by four
    localparam int PROD_W   = 24;            // quotient times reciprocal
    localparam int RECIP_SHIFT = 16;
    localparam int CENT_W   = PROD_W - RECIP_SHIFT;
    localparam int OFFS_W   = 9;             // day within year, 0..365
    localparam int DBM_W    = 9;

    // Default upper bound on a valid year.
    localparam int unsigned MAX_YEAR_DEF = 9999;

    // Division by 25 as multiply and shift; exact for quotients below 4096.
    localparam logic [QUOT_W-1:0] RECIP_25 = QUOT_W'(2622);
    localparam logic [QUOT_W-1:0] DIV_25   = QUOT_W'(25);
    localparam logic [DNUM_W-1:0] DAYS_PER_YEAR = DNUM_W'(365);

    // Calendar constants.
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   LEAP_DAY  = DAY_W'(29);

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FIRST_BAD  = 2'd1,
        ST_SECOND_BAD = 2'd2
    } t_status;

    // One date after the first stage.
    typedef struct packed {
        logic                basic_ok;
        logic                len_ok;
        logic                feb29;
        logic [1:0]          ylow;
        logic [QUOT_W-1:0]   yq;
        logic [PROD_W-1:0]   prod_y;
        logic [YEAR_W-1:0]   p;
        logic [PROD_W-1:0]   prod_p;
        logic [DBM_W-1:0]    dbm;
        logic                after_feb;
        logic [DAY_W-1:0]    d;
    } t_date_s1;

    // One date after the second stage.
    typedef struct packed {
        logic                ok;
        logic [DNUM_W-1:0]   base;
        logic [OFFS_W-1:0]   offs;
    } t_date_s2;

    // Length of a month in a common year; zero for codes that are no month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:                                       len = DAY_W'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of the month.
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] n;
        unique case (m)
            4'd1:    n = DBM_W'(0);
            4'd2:    n = DBM_W'(31);
            4'd3:    n = DBM_W'(59);
            4'd4:    n = DBM_W'(90);
            4'd5:    n = DBM_W'(120);
            4'd6:    n = DBM_W'(151);
            4'd7:    n = DBM_W'(181);
            4'd8:    n = DBM_W'(212);
            4'd9:    n = DBM_W'(243);
            4'd10:   n = DBM_W'(273);
            4'd11:   n = DBM_W'(304);
            4'd12:   n = DBM_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

    // First stage: range checks, table lookups and the two reciprocal products.
    function automatic t_date_s1 date_front(input logic [DAY_W-1:0]   d,
                                            input logic [MONTH_W-1:0] m,
                                            input logic [YEAR_W-1:0]  y,
                                            input logic [MAXY_W-1:0]  max_y);
        t_date_s1           r;
        logic [YEAR_W-1:0]  p;
        logic [QUOT_W-1:0]  yq;
        logic [QUOT_W-1:0]  pq;
        p  = y - YEAR_W'(1);
        yq = y[YEAR_W-1:2];
        pq = p[YEAR_W-1:2];
        r.basic_ok  = (d != '0) && (m != '0) && (y != '0) && (m <= MONTH_DEC)
                      && (MAXY_W'(y) <= max_y);
        r.len_ok    = (d <= month_len(m));
        r.feb29     = (m == MONTH_FEB) && (d == LEAP_DAY);
        r.ylow      = y[1:0];
        r.yq        = yq;
        r.prod_y    = PROD_W'(yq) * PROD_W'(RECIP_25);
        r.p         = p;
        r.prod_p    = PROD_W'(pq) * PROD_W'(RECIP_25);
        r.dbm       = days_before_month(m);
        r.after_feb = (m > MONTH_FEB);
        r.d         = d;
        return r;
    endfunction

    // Second stage: leap rule, final validity, year base and day within year.
    function automatic t_date_s2 date_mid(input t_date_s1 s);
        t_date_s2           r;
        logic [CENT_W-1:0]  cy;
        logic [CENT_W-1:0]  cp;
        logic               leap;
        cy = s.prod_y[PROD_W-1:RECIP_SHIFT];
        cp = s.prod_p[PROD_W-1:RECIP_SHIFT];
        // Divisible by 4 and either not by 100 or also by 400.
        leap = (s.ylow == 2'b00)
               && ((QUOT_W'(cy) * DIV_25 != s.yq) || (cy[1:0] == 2'b00));
        r.ok   = s.basic_ok && (s.len_ok || (s.feb29 && leap));
        r.base = DNUM_W'(s.p) * DAYS_PER_YEAR + DNUM_W'(s.p[YEAR_W-1:2])
                 - DNUM_W'(cp) + DNUM_W'(cp[CENT_W-1:2]);
        r.offs = OFFS_W'(s.dbm) + OFFS_W'(s.after_feb && leap) + OFFS_W'(s.d)
                 - OFFS_W'(1);
        return r;
    endfunction

endpackage

// ===== hdl/calendar_day_difference_unit.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_ready | i_first_*, i_second_* (day, month, year)
// output  | out       | o_out_valid / i_out_ready | o_status, o_days_between
//
// One item is taken per cycle while o_in_ready is high; items leave in the order they arrive.
// The four register stages are front checks, leap and year base, day numbers, difference.
// Synchronous active-low reset clears only the stage valid bits.
// A stall holds each full stage with no gap after it; gaps fill; nothing is lost or repeated.

`include "calendar_day_difference_unit_macros.svh"

module calendar_day_difference_unit #(
    parameter int unsigned MAX_YEAR = cdd_pkg::MAX_YEAR_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [cdd_pkg::DAY_W-1:0]    i_first_day,
    input  logic [cdd_pkg::MONTH_W-1:0]  i_first_month,
    input  logic [cdd_pkg::YEAR_W-1:0]   i_first_year,
    input  logic [cdd_pkg::DAY_W-1:0]    i_second_day,
    input  logic [cdd_pkg::MONTH_W-1:0]  i_second_month,
    input  logic [cdd_pkg::YEAR_W-1:0]   i_second_year,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cdd_pkg::STATUS_W-1:0] o_status,
    output logic [cdd_pkg::DIFF_W-1:0]   o_days_between
);
    import cdd_pkg::*;

    localparam logic [MAXY_W-1:0] MaxYearBound = MAXY_W'(MAX_YEAR);

    // Stage registers.
    logic              r_v1, r_v2, r_v3, r_v4;
    t_date_s1          r_s1_a, r_s1_b;
    t_date_s2          r_s2_a, r_s2_b;
    t_status           r_st2, r_st3, r_status;
    logic [DNUM_W-1:0] r_n3_a, r_n3_b;
    logic [DIFF_W-1:0] r_diff;

    // Next values.
    t_date_s1          n_s1_a, n_s1_b;
    t_date_s2          n_s2_a, n_s2_b;
    t_status           n_st2;
    logic [DNUM_W-1:0] n_n3_a, n_n3_b;
    logic [DIFF_W-1:0] n_diff;
    logic [DNUM_W-1:0] w_abs;

    // A stage may load when it is empty or its contents move on.
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    assign w_rdy4 = !r_v4 || i_out_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    // Stage 1: checks and reciprocal products for both dates.
    assign n_s1_a = date_front(i_first_day, i_first_month, i_first_year, MaxYearBound);
    assign n_s1_b = date_front(i_second_day, i_second_month, i_second_year, MaxYearBound);

    // Stage 2: validity, status and partial day counts.
    assign n_s2_a = date_mid(r_s1_a);
    assign n_s2_b = date_mid(r_s1_b);

    // The first date is judged before the second.
    always_comb begin
        priority if (!n_s2_a.ok) begin
            n_st2 = ST_FIRST_BAD;
        end else if (!n_s2_b.ok) begin
            n_st2 = ST_SECOND_BAD;
        end else begin
            n_st2 = ST_OK;
        end
    end

    // Stage 3: full day numbers from the epoch.
    assign n_n3_a = r_s2_a.base + DNUM_W'(r_s2_a.offs);
    assign n_n3_b = r_s2_b.base + DNUM_W'(r_s2_b.offs);

    // Stage 4: absolute difference, forced to zero for a rejected date.
    assign w_abs  = (r_n3_a > r_n3_b) ? (r_n3_a - r_n3_b) : (r_n3_b - r_n3_a);
    assign n_diff = (r_st3 == ST_OK) ? w_abs[DIFF_W-1:0] : '0;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_a <= n_s1_a;
            r_s1_b <= n_s1_b;
        end
        if (w_rdy2) begin
            r_s2_a <= n_s2_a;
            r_s2_b <= n_s2_b;
            r_st2  <= n_st2;
        end
        if (w_rdy3) begin
            r_n3_a <= n_n3_a;
            r_n3_b <= n_n3_b;
            r_st3  <= r_st2;
        end
        if (w_rdy4) begin
            r_diff   <= n_diff;
            r_status <= r_st3;
        end
    end

    // Ports.
    assign o_in_ready     = w_rdy1;
    assign o_out_valid    = r_v4;
    assign o_status       = r_status;
    assign o_days_between = r_diff;

    // Checks.
    `CDD_ASSERT_SAME(a_bad_gives_zero, i_clk, i_rst_n,
        r_v4 && (r_status != ST_OK), r_diff == '0, "rejected date with nonzero day count")
    `CDD_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_v4 && !i_out_ready,
        r_v4 && $stable(r_diff) && $stable(r_status), "stalled item lost or changed")
    `CDD_ASSERT_NEXT(a_in_taken, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_v1, "accepted item missing in first stage")
    `CDD_ASSERT_NEXT(a_s3_held, i_clk, i_rst_n, r_v3 && !w_rdy4,
        r_v3 && $stable(r_n3_a) && $stable(r_n3_b), "third stage changed while blocked")

endmodule
